[hdl/twa_pkg.sv]
package twa_pkg;

    localparam int TIME_BITS = 31;
    localparam int WIN_BITS  = 32;
    localparam int CNT_BITS  = $clog2(TIME_BITS);

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_SLIDE_SIZE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TS,
        ST_DIV_PH,
        ST_DIV_CW,
        ST_FINISH
    } twa_state_t;

    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] dividend;
        logic [TIME_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hdl/twa_rem_unit.sv]
module twa_rem_unit
    import twa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output div_stat_t            stat,
    output logic [TIME_BITS-1:0] rem
);

    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] dvd_reg, dvd_next;
    logic [TIME_BITS-1:0] dsr_reg, dsr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [TIME_BITS:0]   partial;
    logic                 ge;

    // restoring step: shift in the next dividend bit, subtract if it fits
    assign partial = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign ge      = partial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = CNT_BITS'(TIME_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? TIME_BITS'(partial - {1'b0, dsr_reg}) : partial[TIME_BITS-1:0];
            dvd_next = {dvd_reg[TIME_BITS-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

[hdl/time_window_assigner_unit.sv]
// channel   dir  handshake               payload
// in        in   in_valid / in_ready     timestamp
// out       out  out_valid / out_ready   first_window, last_window, dropped,
//                                        window_opened, window_closed, closed_id
// cfg       in   cfg_we                  cfg_index, cfg_data
//
// each remainder by the slide size is one pass of the shared radix-2 unit (31 steps),
// one to three passes per item
// the result sits in an output register, so the next beat is taken while it waits
// reset clears the window state, sets the newest window id to all ones and both size registers to 1
module time_window_assigner_unit
    import twa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [TIME_BITS-1:0]        timestamp,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [TIME_BITS-1:0]        first_window,
    output logic signed [WIN_BITS-1:0]  last_window,
    output logic                        dropped,
    output logic                        window_opened,
    output logic                        window_closed,
    output logic [TIME_BITS-1:0]        closed_id,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [TIME_BITS-1:0]        cfg_data
);

    twa_state_t           state_reg, state_next;
    logic [TIME_BITS-1:0] window_size_reg, slide_size_reg;

    logic [TIME_BITS-1:0] ts_reg, ts_next;
    logic                 first_reg, first_next;
    logic                 adv_reg, adv_next;
    logic [TIME_BITS-1:0] rem_ts_reg, rem_ts_next;
    logic [TIME_BITS-1:0] phase_eff_reg, phase_eff_next;
    logic                 cw_match_reg, cw_match_next;

    logic                 seen_reg, seen_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] phase_reg, phase_next;
    logic [TIME_BITS-1:0] clock_reg, clock_next;
    logic [TIME_BITS-1:0] active_reg, active_next;
    logic [WIN_BITS-1:0]  newest_reg, newest_next;

    logic                 out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0] first_window_reg, first_window_next;
    logic [WIN_BITS-1:0]  last_window_reg, last_window_next;
    logic                 dropped_reg, dropped_next;
    logic                 opened_reg, opened_next;
    logic                 closed_reg, closed_next;
    logic [TIME_BITS-1:0] closed_id_reg, closed_id_next;

    div_req_t             div_req;
    div_stat_t            div_stat;
    logic [TIME_BITS-1:0] div_rem;

    logic [TIME_BITS-1:0] eff_slide;
    logic                 need_cw;
    logic [TIME_BITS-1:0] start_eff;
    logic                 fin_opened, fin_closed, fin_dropped;
    logic [TIME_BITS:0]   gap_off;
    logic [TIME_BITS-1:0] active_upd;
    logic [WIN_BITS-1:0]  newest_upd;

    twa_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat),
        .rem   (div_rem)
    );

    assign eff_slide = (slide_size_reg == '0) ? TIME_BITS'(1) : slide_size_reg;
    // a later close only when the shifted clock lands on the phase
    assign need_cw   = adv_reg && (active_reg != '0) && (ts_reg >= window_size_reg);
    assign start_eff = first_reg ? ts_reg : start_reg;

    assign fin_opened = adv_reg && (rem_ts_reg == phase_eff_reg);
    assign fin_closed = adv_reg && ((active_reg == '0)
                        ? ((ts_reg - start_eff) >= window_size_reg) : cw_match_reg);
    // offset of the record inside the slide, measured from the phase
    assign gap_off = (rem_ts_reg >= phase_eff_reg)
                     ? {1'b0, rem_ts_reg - phase_eff_reg}
                     : ({1'b0, rem_ts_reg} + {1'b0, eff_slide}) - {1'b0, phase_eff_reg};
    assign fin_dropped = (eff_slide > window_size_reg) && (gap_off >= {1'b0, window_size_reg});
    assign active_upd  = active_reg + TIME_BITS'(fin_closed);
    assign newest_upd  = newest_reg + WIN_BITS'(fin_opened);

    always_comb
    begin
        state_next        = state_reg;
        ts_next           = ts_reg;
        first_next        = first_reg;
        adv_next          = adv_reg;
        rem_ts_next       = rem_ts_reg;
        phase_eff_next    = phase_eff_reg;
        cw_match_next     = cw_match_reg;
        seen_next         = seen_reg;
        start_next        = start_reg;
        phase_next        = phase_reg;
        clock_next        = clock_reg;
        active_next       = active_reg;
        newest_next       = newest_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        first_window_next = first_window_reg;
        last_window_next  = last_window_reg;
        dropped_next      = dropped_reg;
        opened_next       = opened_reg;
        closed_next       = closed_reg;
        closed_id_next    = closed_id_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = timestamp;
        div_req.divisor   = eff_slide;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ts_next       = timestamp;
                    first_next    = !seen_reg;
                    adv_next      = !seen_reg || (clock_reg < timestamp);
                    cw_match_next = 1'b0;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_TS;
                end
            end
            ST_DIV_TS:
            begin
                if (div_stat.done)
                begin
                    rem_ts_next = div_rem;
                    if (first_reg)
                    begin
                        // first beat: phase is this remainder, no later close possible
                        phase_eff_next = div_rem;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = phase_reg;
                        state_next       = ST_DIV_PH;
                    end
                end
            end
            ST_DIV_PH:
            begin
                if (div_stat.done)
                begin
                    phase_eff_next = div_rem;
                    if (need_cw)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = ts_reg - window_size_reg;
                        state_next       = ST_DIV_CW;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_CW:
            begin
                if (div_stat.done)
                begin
                    cw_match_next = (div_rem == phase_eff_reg);
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    seen_next = 1'b1;
                    if (first_reg)
                    begin
                        start_next = ts_reg;
                        phase_next = rem_ts_reg;
                    end
                    if (adv_reg)
                    begin
                        clock_next = ts_reg;
                    end
                    active_next       = active_upd;
                    newest_next       = newest_upd;
                    out_valid_next    = 1'b1;
                    first_window_next = fin_dropped ? '0 : active_upd;
                    last_window_next  = fin_dropped ? '0 : newest_upd;
                    dropped_next      = fin_dropped;
                    opened_next       = fin_opened;
                    closed_next       = fin_closed;
                    closed_id_next    = fin_closed ? active_reg : '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= TIME_BITS'(1);
            slide_size_reg  <= TIME_BITS'(1);
            seen_reg        <= 1'b0;
            start_reg       <= '0;
            phase_reg       <= '0;
            clock_reg       <= '0;
            active_reg      <= '0;
            newest_reg      <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            phase_reg     <= phase_next;
            clock_reg     <= clock_next;
            active_reg    <= active_next;
            newest_reg    <= newest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                    REG_SLIDE_SIZE:  slide_size_reg  <= cfg_data;
                    default:         window_size_reg <= window_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg           <= ts_next;
        first_reg        <= first_next;
        adv_reg          <= adv_next;
        rem_ts_reg       <= rem_ts_next;
        phase_eff_reg    <= phase_eff_next;
        cw_match_reg     <= cw_match_next;
        first_window_reg <= first_window_next;
        last_window_reg  <= last_window_next;
        dropped_reg      <= dropped_next;
        opened_reg       <= opened_next;
        closed_reg       <= closed_next;
        closed_id_reg    <= closed_id_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign first_window  = first_window_reg;
    assign last_window   = $signed(last_window_reg);
    assign dropped       = dropped_reg;
    assign window_opened = opened_reg;
    assign window_closed = closed_reg;
    assign closed_id     = closed_id_reg;

    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_stat.busy)
        else $error("remainder unit busy while taking a beat");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("beat taken while previous beat still in work");

    a_close_bumps_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && window_closed && !dropped)
            |-> (first_window == TIME_BITS'(closed_id + 1'b1)))
        else $error("closed window id does not precede first window");

endmodule

[tb/window_tag_checker.sv]
module window_tag_checker
    import twa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [TIME_BITS-1:0]        timestamp,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [TIME_BITS-1:0]        first_window,
    input  logic signed [WIN_BITS-1:0]  last_window,
    input  logic                        dropped,
    input  logic                        window_opened,
    input  logic                        window_closed,
    input  logic [TIME_BITS-1:0]        closed_id,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [TIME_BITS-1:0]        cfg_data,
    output int                          mismatches,
    output int                          tags_in_flight
);

    typedef struct packed {
        logic [TIME_BITS-1:0]        first;
        logic signed [WIN_BITS-1:0]  last;
        logic                        drop;
        logic                        opened;
        logic                        closed;
        logic [TIME_BITS-1:0]        cid;
    } window_tag_t;

    // copy of the size registers and window bookkeeping
    logic [TIME_BITS-1:0]  window_len;
    logic [TIME_BITS-1:0]  slide_len;
    logic                  started;
    logic [TIME_BITS-1:0]  first_ts;
    logic [TIME_BITS-1:0]  phase;
    logic [TIME_BITS-1:0]  clock_now;
    logic [TIME_BITS-1:0]  active_id;
    logic [WIN_BITS-1:0]   newest_id;

    window_tag_t tag_queue[$];

    function automatic window_tag_t assign_windows(input logic [TIME_BITS-1:0] ts);
        logic [31:0] s;
        logic [31:0] w;
        logic [31:0] ph;
        logic [31:0] gap_off;
        logic        advanced;
        window_tag_t t;
        // zero slide behaves as a slide of one
        s = (slide_len == '0) ? 32'd1 : {1'b0, slide_len};
        w = {1'b0, window_len};
        t = '0;
        advanced = 1'b0;
        if (!started) begin
            started = 1'b1;
            first_ts = ts;
            phase = TIME_BITS'({1'b0, ts} % s);
            clock_now = ts;
            advanced = 1'b1;
        end
        else if (clock_now < ts) begin
            clock_now = ts;
            advanced = 1'b1;
        end
        if (advanced) begin
            ph = {1'b0, phase} % s;
            if ({1'b0, clock_now} % s == ph) begin
                newest_id = newest_id + 1;
                t.opened = 1'b1;
            end
            if (active_id == '0)
                t.closed = ({1'b0, clock_now} - {1'b0, first_ts}) >= w;
            else
                t.closed = (clock_now >= window_len)
                           && ((({1'b0, clock_now} - w) % s) == ph);
            if (t.closed) begin
                t.cid = active_id;
                active_id = active_id + 1'b1;
            end
        end
        // offset from the slide phase decides whether the record sits in a gap
        gap_off = (({1'b0, ts} % s) + s - ({1'b0, phase} % s)) % s;
        t.drop = (s > w) && (gap_off >= w);
        if (!t.drop) begin
            t.first = active_id;
            t.last = newest_id;
        end
        return t;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        window_tag_t want;
        if (!rst_n) begin
            window_len = TIME_BITS'(1);
            slide_len = TIME_BITS'(1);
            started = 1'b0;
            first_ts = '0;
            phase = '0;
            clock_now = '0;
            active_id = '0;
            newest_id = '1;
            tag_queue.delete();
            mismatches = 0;
            tags_in_flight = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_WINDOW_SIZE)
                    window_len = cfg_data;
                else
                    slide_len = cfg_data;
            end
            if (out_valid && out_ready) begin
                if (tag_queue.size() == 0) begin
                    $display("%0t: unexpected result beat first_window %h last_window %h",
                             $time, first_window, last_window);
                    mismatches++;
                end
                else begin
                    want = tag_queue.pop_front();
                    check_field("first_window", 32'(want.first), 32'(first_window));
                    check_field("last_window", want.last, last_window);
                    check_field("dropped", 32'(want.drop), 32'(dropped));
                    check_field("window_opened", 32'(want.opened), 32'(window_opened));
                    check_field("window_closed", 32'(want.closed), 32'(window_closed));
                    check_field("closed_id", 32'(want.cid), 32'(closed_id));
                end
            end
            if (in_valid && in_ready)
                tag_queue.push_back(assign_windows(timestamp));
            tags_in_flight = tag_queue.size();
        end
    end

endmodule

[tb/tb_time_window_assigner_unit.sv]
module tb_time_window_assigner_unit;
    import twa_pkg::*;

    localparam logic [TIME_BITS-1:0] TS_MAX = '1;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [TIME_BITS-1:0]        timestamp = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [TIME_BITS-1:0]        first_window;
    logic signed [WIN_BITS-1:0]  last_window;
    logic                        dropped;
    logic                        window_opened;
    logic                        window_closed;
    logic [TIME_BITS-1:0]        closed_id;
    logic                        cfg_we = 1'b0;
    logic                        cfg_index = REG_WINDOW_SIZE;
    logic [TIME_BITS-1:0]        cfg_data = '0;

    int                          mismatches;
    int                          tags_in_flight;
    logic                        steady = 1'b0;
    int                          stall_left = 0;
    // highest timestamp sent so far, tracks the block's clock
    logic [TIME_BITS-1:0]        clock_ts = '0;

    time_window_assigner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .timestamp     (timestamp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .first_window  (first_window),
        .last_window   (last_window),
        .dropped       (dropped),
        .window_opened (window_opened),
        .window_closed (window_closed),
        .closed_id     (closed_id),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    window_tag_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .timestamp      (timestamp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_window   (first_window),
        .last_window    (last_window),
        .dropped        (dropped),
        .window_opened  (window_opened),
        .window_closed  (window_closed),
        .closed_id      (closed_id),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .tags_in_flight (tags_in_flight)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver stalls at random in bursts
    always @(negedge clk) begin
        if (steady) begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic push_ts(input logic [TIME_BITS-1:0] ts);
        int gap;
        gap = (!steady && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        timestamp <= ts;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (ts > clock_ts)
            clock_ts = ts;
        @(negedge clk);
    endtask

    // sizes change only once every result is back
    task automatic set_sizes(input logic [TIME_BITS-1:0] win_len,
                             input logic [TIME_BITS-1:0] slide_len);
        in_valid <= 1'b0;
        while (tags_in_flight != 0) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_WINDOW_SIZE;
        cfg_data <= win_len;
        @(negedge clk);
        cfg_index <= REG_SLIDE_SIZE;
        cfg_data <= slide_len;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly advancing timestamps, with repeats and late records mixed in
    task automatic run_stream(input int count, input int step_max);
        int          pick;
        logic [31:0] nxt;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                nxt = {1'b0, clock_ts} + 32'($urandom_range(1, step_max));
                if (nxt > {1'b0, TS_MAX})
                    nxt = {1'b0, TS_MAX};
            end
            else if (pick < 82) begin
                nxt = {1'b0, clock_ts};
            end
            else begin
                nxt = $urandom_range(0, clock_ts);
            end
            push_ts(nxt[TIME_BITS-1:0]);
        end
    endtask

    initial begin
        int ws;
        int ss;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first record sets start and phase, then repeats, late ones and closes
        set_sizes(25, 10);
        push_ts(37);
        push_ts(37);
        push_ts(30);
        push_ts(0);
        push_ts(47);
        push_ts(62);
        push_ts(67);
        push_ts(72);
        push_ts(77);
        // slide larger than window: gaps, phase no longer below the slide
        set_sizes(3, 7);
        push_ts(78);
        push_ts(82);
        push_ts(60);
        push_ts(84);
        // zero window and zero slide
        set_sizes(0, 0);
        push_ts(85);
        push_ts(85);
        push_ts(90);
        // clock stays below the window size
        set_sizes(TS_MAX, 4);
        push_ts(100);
        push_ts(104);
        set_sizes(TS_MAX, TS_MAX);
        push_ts(200);
        push_ts(150);

        set_sizes(25, 10);
        run_stream(300, 12);
        set_sizes(3, 7);
        run_stream(250, 9);
        set_sizes(5, 5);
        run_stream(150, 6);
        set_sizes(0, 0);
        run_stream(100, 3);
        repeat (3) begin
            ws = $urandom_range(1, 20);
            ss = $urandom_range(1, 20);
            set_sizes(TIME_BITS'(ws), TIME_BITS'(ss));
            run_stream(100, ss + 2);
        end
        set_sizes(40, 3);
        push_ts(TIME_BITS'(clock_ts + (1 << 30)));
        run_stream(200, 4);
        set_sizes(TS_MAX, 6);
        run_stream(120, 7);
        set_sizes(2, TS_MAX);
        run_stream(120, 64);
        set_sizes(1, 1);
        run_stream(100, 2);

        // no idling from here on, climbing to the top of the timestamp range
        set_sizes(16, 9);
        steady = 1'b1;
        push_ts(TIME_BITS'(TS_MAX - 800));
        run_stream(280, 10);
        push_ts(TS_MAX);
        push_ts(TS_MAX);

        in_valid <= 1'b0;
        while (tags_in_flight != 0) @(negedge clk);
        repeat (120) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hdl/twa_pkg.sv
hdl/twa_rem_unit.sv
hdl/time_window_assigner_unit.sv
tb/window_tag_checker.sv
tb/tb_time_window_assigner_unit.sv
